// ===== src/prd_pkg.sv =====
// Package for the length-prefixed packet receive deframer.
// Holds the register indexes, result kind codes and shared types.
// No dependencies; every other file of the block uses it.
package prd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUNT_TIMEOUT = 2'd3;

  localparam logic [7:0]  MAGIC_RESET   = 8'd37;
  localparam logic [15:0] MAX_LEN_RESET = 16'd0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_BODY    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_LEN_ERR = 2'd3;

  typedef struct packed {
    logic [7:0]  magic_byte;
    logic [15:0] max_len;
    logic [15:0] byte_timeout_ticks;
    logic [15:0] hunt_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        ack_req;
    logic        last;
  } result_t;

endpackage

// ===== src/prd_if.sv =====
// Handshake channel interfaces of the deframer: received events,
// results and configuration writes. Depends on prd_pkg for widths.
interface prd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface prd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  command;
  logic [15:0] length;
  logic [7:0]  data_byte;
  logic        ack_req;
  logic        last;
  modport source (output valid, kind, command, length, data_byte, ack_req, last,
                  input ready);
  modport sink (input valid, kind, command, length, data_byte, ack_req, last,
                output ready);
endinterface

interface prd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [prd_pkg::CFG_IDX_W-1:0]  index;
  logic [prd_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/prd_cfg.sv =====
// Configuration register file of the deframer.
// Depends on prd_pkg and the prd_cfg_if interface.
module prd_cfg (
  input  logic           clk,
  input  logic           rst,
  prd_cfg_if.sink        cfg,
  output prd_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.magic_byte         <= prd_pkg::MAGIC_RESET;
      regs.max_len            <= prd_pkg::MAX_LEN_RESET;
      regs.byte_timeout_ticks <= prd_pkg::TIMEOUT_RESET;
      regs.hunt_timeout_ticks <= prd_pkg::TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        prd_pkg::CFG_MAGIC:        regs.magic_byte         <= cfg.data[7:0];
        prd_pkg::CFG_MAX_LEN:      regs.max_len            <= cfg.data;
        prd_pkg::CFG_BYTE_TIMEOUT: regs.byte_timeout_ticks <= cfg.data;
        prd_pkg::CFG_HUNT_TIMEOUT: regs.hunt_timeout_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/prd_core.sv =====
// Framing state and next-state logic of the deframer.
// Depends on prd_pkg; produces at most one result per accepted event.
module prd_core #(
  parameter int unsigned BLOCK_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [7:0]        rx_byte,
  input  prd_pkg::cfg_t     regs,
  output logic              res_valid,
  output prd_pkg::result_t  res
);

  localparam int unsigned FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_BYTES);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LLO  = 3'd2;
  localparam logic [2:0] PH_LHI  = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [7:0]        held_command, held_command_next;
  logic [7:0]        low_length_byte, low_length_byte_next;
  logic [15:0]       held_length, held_length_next;
  logic [15:0]       bytes_remaining, bytes_remaining_next;
  logic [FILL_W-1:0] block_fill, block_fill_next;
  logic [15:0]       idle_ticks, idle_ticks_next;

  logic        hunting;
  logic [15:0] idle_inc;
  logic [15:0] limit;
  logic [15:0] new_length;
  logic [15:0] rem_dec;
  logic [FILL_W-1:0] fill_inc;

  assign hunting    = !(phase == PH_CMD || phase == PH_LLO || phase == PH_LHI ||
                        phase == PH_BODY);
  assign idle_inc   = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign limit      = hunting ? regs.hunt_timeout_ticks : regs.byte_timeout_ticks;
  assign new_length = {rx_byte, low_length_byte};
  assign rem_dec    = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : 16'd0;
  assign fill_inc   = block_fill + FILL_W'(1);

  always_comb begin
    phase_next           = phase;
    held_command_next    = held_command;
    low_length_byte_next = low_length_byte;
    held_length_next     = held_length;
    bytes_remaining_next = bytes_remaining;
    block_fill_next      = block_fill;
    idle_ticks_next      = idle_ticks;
    res_valid            = 1'b0;
    res                  = '0;

    if (action == prd_pkg::ACT_TICK) begin
      if (idle_inc >= limit) begin
        res_valid       = 1'b1;
        res.kind        = prd_pkg::KIND_TIMEOUT;
        res.command     = hunting ? 8'd0 : held_command;
        res.length      = hunting ? 16'd0 : held_length;
        res.last        = 1'b1;
        idle_ticks_next = 16'd0;
        phase_next      = PH_HUNT;
      end else begin
        idle_ticks_next = idle_inc;
      end
    end else begin
      idle_ticks_next = 16'd0;
      if (hunting) begin
        phase_next = PH_HUNT;
        if (rx_byte == regs.magic_byte) begin
          held_command_next    = 8'd0;
          low_length_byte_next = 8'd0;
          held_length_next     = 16'd0;
          bytes_remaining_next = 16'd0;
          block_fill_next      = '0;
          phase_next           = PH_CMD;
        end
      end else begin
        unique case (phase)
          PH_CMD: begin
            held_command_next = rx_byte;
            phase_next        = PH_LLO;
          end
          PH_LLO: begin
            low_length_byte_next = rx_byte;
            phase_next           = PH_LHI;
          end
          PH_LHI: begin
            held_length_next = new_length;
            res_valid        = 1'b1;
            res.command      = held_command;
            res.length       = new_length;
            res.ack_req      = 1'b1;
            if (regs.max_len != 16'd0 && new_length > regs.max_len) begin
              res.kind   = prd_pkg::KIND_LEN_ERR;
              res.last   = 1'b1;
              phase_next = PH_HUNT;
            end else begin
              res.kind             = prd_pkg::KIND_HEADER;
              bytes_remaining_next = new_length;
              block_fill_next      = '0;
              res.last             = (new_length == 16'd0);
              phase_next           = (new_length == 16'd0) ? PH_HUNT : PH_BODY;
            end
          end
          default: begin
            // Body byte: an acknowledgement closes each full block and the packet.
            res_valid            = 1'b1;
            res.kind             = prd_pkg::KIND_BODY;
            res.command          = held_command;
            res.length           = held_length;
            res.data_byte        = rx_byte;
            bytes_remaining_next = rem_dec;
            if (fill_inc >= FILL_FULL || rem_dec == 16'd0) begin
              res.ack_req     = 1'b1;
              block_fill_next = '0;
            end else begin
              block_fill_next = fill_inc;
            end
            if (rem_dec == 16'd0) begin
              res.last   = 1'b1;
              phase_next = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      held_command    <= 8'd0;
      low_length_byte <= 8'd0;
      held_length     <= 16'd0;
      bytes_remaining <= 16'd0;
      block_fill      <= '0;
      idle_ticks      <= 16'd0;
    end else if (accept) begin
      phase           <= phase_next;
      held_command    <= held_command_next;
      low_length_byte <= low_length_byte_next;
      held_length     <= held_length_next;
      bytes_remaining <= bytes_remaining_next;
      block_fill      <= block_fill_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

endmodule

// ===== src/prd_obuf.sv =====
// Result register of the deframer, driving the result channel.
// Depends on prd_pkg and the prd_out_if interface.
module prd_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  prd_pkg::result_t  res,
  output logic              can_take,
  prd_out_if.source         res_out
);

  logic             valid;
  prd_pkg::result_t data;

  assign can_take = !valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      data <= res;
    end
  end

  assign res_out.valid     = valid;
  assign res_out.kind      = data.kind;
  assign res_out.command   = data.command;
  assign res_out.length    = data.length;
  assign res_out.data_byte = data.data_byte;
  assign res_out.ack_req   = data.ack_req;
  assign res_out.last      = data.last;

endmodule

// ===== src/packet_receive_deframer.sv =====
// Top level of the length-prefixed packet receive deframer.
// Depends on prd_pkg, the channel interfaces, prd_cfg, prd_core and prd_obuf.
//
// The deframer takes one event per transfer on rx_in, either a received byte
// or a time tick, and accepts a new event in every clock cycle as long as the
// result register is empty or its result is being taken in the same cycle.
// The framing state is updated at the transfer, and the result that the event
// causes, if any, is presented on res_out in the following cycle from the
// single result register, which lets the block take one event per cycle. While
// hunting, bytes are dropped until the magic byte arrives; then a command
// byte and a little-endian 16-bit length follow. The header result requests
// an acknowledgement, a body longer than a nonzero max_len gives a length
// error instead, and body bytes are passed through with an acknowledgement
// request after each full block of BLOCK_BYTES bytes and after the final
// byte. Too many ticks without a byte give a timeout result and return the
// block to hunting. Configuration writes on cfg are always taken and should
// be made only while the block is idle.
module packet_receive_deframer #(
  parameter int unsigned BLOCK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  prd_in_if.sink      rx_in,
  prd_out_if.source   res_out,
  prd_cfg_if.sink     cfg
);

  prd_pkg::cfg_t    regs;
  prd_pkg::result_t res;
  logic             res_valid;
  logic             can_take;
  logic             accept;

  // An event is taken only when its result, if any, has a place to go.
  assign rx_in.ready = can_take;
  assign accept      = rx_in.valid && can_take;

  prd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  prd_core #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (rx_in.action),
    .rx_byte   (rx_in.rx_byte),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  prd_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && res_valid),
    .res      (res),
    .can_take (can_take),
    .res_out  (res_out)
  );

endmodule

// ===== src/prd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on prd_pkg for the result kind codes.
module prd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  command,
  input logic [15:0] length,
  input logic [7:0]  data_byte,
  input logic        ack_req,
  input logic        last
);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("event channel stalled while no result is held");

  a_timeout_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == prd_pkg::KIND_TIMEOUT |-> !ack_req && last &&
      data_byte == 8'd0)
    else $error("timeout result with wrong flags");

  a_len_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == prd_pkg::KIND_LEN_ERR |-> ack_req && last &&
      length != 16'd0)
    else $error("length error result with wrong fields");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(command) &&
      $stable(length) && $stable(data_byte) && $stable(ack_req) && $stable(last))
    else $error("stalled result changed");

endmodule

bind packet_receive_deframer prd_checker u_prd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (rx_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .kind      (res_out.kind),
  .command   (res_out.command),
  .length    (res_out.length),
  .data_byte (res_out.data_byte),
  .ack_req   (res_out.ack_req),
  .last      (res_out.last)
);
